[src/hcb_pkg.sv]
`default_nettype none

package hcb_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] cfg_idx_t;

	// register map
	localparam cfg_idx_t REG_K00 = 3'd0;
	localparam cfg_idx_t REG_K01 = 3'd1;
	localparam cfg_idx_t REG_K10 = 3'd2;
	localparam cfg_idx_t REG_K11 = 3'd3;
	localparam cfg_idx_t REG_DEC = 3'd4;

	// effective matrix used by the datapath (key or its inverse mod 256)
	typedef struct packed {
		byte_t m00;
		byte_t m01;
		byte_t m10;
		byte_t m11;
		logic  err;
	} key_t;

endpackage

`default_nettype wire

[src/hcb_if.sv]
`default_nettype none

interface hcb_in_if;
	logic           valid;
	logic           ready;
	hcb_pkg::byte_t data_byte;
	logic           last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hcb_out_if;
	logic           valid;
	logic           ready;
	hcb_pkg::byte_t first_out;
	hcb_pkg::byte_t second_out;
	logic           key_error;

	modport source (output valid, output first_out, output second_out, output key_error,
		input ready);
	modport sink (input valid, input first_out, input second_out, input key_error,
		output ready);
endinterface

interface hcb_cfg_if;
	logic              valid;
	logic              ready;
	hcb_pkg::cfg_idx_t index;
	hcb_pkg::byte_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/hcb_key_setup.sv]
`default_nettype none

module hcb_key_setup (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  hcb_pkg::cfg_idx_t cfg_idx,
	input  hcb_pkg::byte_t    cfg_data,
	output hcb_pkg::key_t     key,
	output logic              busy
);
	import hcb_pkg::*;

	localparam logic [2:0] STEP_IDLE  = 3'd0;
	localparam logic [2:0] STEP_PROD  = 3'd1;
	localparam logic [2:0] STEP_DET   = 3'd2;
	localparam logic [2:0] STEP_NEWT1 = 3'd3;
	localparam logic [2:0] STEP_CHK   = 3'd4;
	localparam logic [2:0] STEP_NEWT2 = 3'd5;
	localparam logic [2:0] STEP_MAT   = 3'd6;

	byte_t      k00_q, k01_q, k10_q, k11_q;
	logic       dec_q;
	logic [2:0] step_q;
	byte_t      pa_q, pb_q, det_q, dx_q, x_q;
	key_t       key_q;
	byte_t      det_c;

	assign det_c = pa_q - pb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k00_q  <= 8'd1;
			k01_q  <= 8'd0;
			k10_q  <= 8'd0;
			k11_q  <= 8'd1;
			dec_q  <= 1'b0;
			step_q <= STEP_IDLE;
			key_q  <= '{m00: 8'd1, m01: 8'd0, m10: 8'd0, m11: 8'd1, err: 1'b0};
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_K00: k00_q <= cfg_data;
				REG_K01: k01_q <= cfg_data;
				REG_K10: k10_q <= cfg_data;
				REG_K11: k11_q <= cfg_data;
				REG_DEC: dec_q <= cfg_data[0];
				default: ;
			endcase
			step_q <= STEP_PROD;
		end else begin
			case (step_q)
				STEP_IDLE:  step_q <= STEP_IDLE;
				STEP_MAT: begin
					step_q <= STEP_IDLE;
					if (!dec_q) begin
						key_q <= '{m00: k00_q, m01: k01_q, m10: k10_q, m11: k11_q, err: 1'b0};
					end else if (!det_q[0]) begin
						// even determinant: no inverse, zero the matrix and flag it
						key_q <= '{m00: 8'd0, m01: 8'd0, m10: 8'd0, m11: 8'd0, err: 1'b1};
					end else begin
						key_q.m00 <= k11_q * x_q;
						key_q.m01 <= 8'd0 - k01_q * x_q;
						key_q.m10 <= 8'd0 - k10_q * x_q;
						key_q.m11 <= k00_q * x_q;
						key_q.err <= 1'b0;
					end
				end
				default: step_q <= step_q + 3'd1;
			endcase
		end
	end

	// determinant and its inverse: Newton steps x <- x*(2 - d*x), one multiply level per step
	always_ff @(posedge clk) begin
		case (step_q)
			STEP_PROD: begin
				pa_q <= k00_q * k11_q;
				pb_q <= k01_q * k10_q;
			end
			STEP_DET: begin
				det_q <= det_c;
				x_q   <= det_c;
				dx_q  <= det_c * det_c;
			end
			STEP_NEWT1: x_q <= x_q * (8'd2 - dx_q);
			STEP_CHK:   dx_q <= det_q * x_q;
			STEP_NEWT2: x_q <= x_q * (8'd2 - dx_q);
			default: ;
		endcase
	end

	assign key  = key_q;
	assign busy = (step_q != STEP_IDLE);

	// the flag may be stale while a setup runs
	a_err_needs_dec: assert property (@(posedge clk) disable iff (!arst_n)
		key_q.err && step_q == STEP_IDLE |-> dec_q)
		else $error("key error flagged in encrypt mode");

	a_write_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> step_q == STEP_PROD)
		else $error("config write did not restart key setup");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == STEP_MAT && !cfg_we |=> step_q == STEP_IDLE)
		else $error("key setup did not finish");

endmodule

`default_nettype wire

[src/hcb_datapath.sv]
`default_nettype none

module hcb_datapath (
	input  logic          clk,
	input  logic          arst_n,
	hcb_in_if.sink        src,
	hcb_out_if.source     dst,
	input  hcb_pkg::key_t key,
	input  logic          busy
);
	import hcb_pkg::*;

	byte_t held_q;
	logic  holding_q;
	byte_t p0_s1, p1_s1;
	logic  vld_s1;
	byte_t first_q, second_q;
	logic  err_q, vld_q;
	logic  out_adv, acc, pair;

	assign out_adv   = !vld_q || dst.ready;
	assign src.ready = !busy && (!vld_s1 || out_adv);
	assign acc       = src.valid && src.ready;
	assign pair      = acc && holding_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q <= 1'b0;
			vld_s1    <= 1'b0;
			vld_q     <= 1'b0;
		end else begin
			// a first byte with the last mark is dropped and pairing stays clear
			if (acc)
				holding_q <= !holding_q && !src.last_byte;
			if (pair)
				vld_s1 <= 1'b1;
			else if (out_adv)
				vld_s1 <= 1'b0;
			if (out_adv)
				vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !holding_q)
			held_q <= src.data_byte;
		if (pair) begin
			p0_s1 <= held_q;
			p1_s1 <= src.data_byte;
		end
		if (out_adv) begin
			first_q  <= key.m00 * p0_s1 + key.m01 * p1_s1;
			second_q <= key.m10 * p0_s1 + key.m11 * p1_s1;
			err_q    <= key.err;
		end
	end

	assign dst.valid      = vld_q;
	assign dst.first_out  = first_q;
	assign dst.second_out = second_q;
	assign dst.key_error  = err_q;

endmodule

`default_nettype wire

[src/hill_cipher_2x2_byte_pairs.sv]
// 2x2 Hill cipher over byte pairs, mod 256.
// src: input bytes (data_byte, last_byte), valid/ready. Bytes pair up in
//   arrival order; the second byte of a pair yields one item on dst. A first
//   byte carrying last_byte is dropped and pairing restarts.
// dst: first_out, second_out, key_error, valid/ready. key_error is set, with
//   zero bytes, when decrypting under a key with even determinant.
// cfg: register writes (index, data), always ready. Index 0..3 are the key
//   entries k00, k01, k10, k11; index 4 selects decrypt. Other indexes ignored.
// Throughput: one byte per cycle while no key setup runs and dst is ready.
//   A result passes the input stage, then the result register, to dst.
// Each config write restarts the key setup (determinant, Newton
//   inverse, matrix), one multiply level per cycle; src.ready is low meanwhile.
// Reset: identity key, encrypt mode, no byte held, no result pending.
// A stalled dst holds its item; the input stage keeps taking bytes until it
//   also fills; outside key setup src.ready drops only when both are full.
`default_nettype none

module hill_cipher_2x2_byte_pairs (
	input logic       clk,
	input logic       arst_n,
	hcb_in_if.sink    src,
	hcb_out_if.source dst,
	hcb_cfg_if.sink   cfg
);
	import hcb_pkg::*;

	key_t key;
	logic busy;
	logic cfg_we;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	hcb_key_setup u_key (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg.index),
		.cfg_data (cfg.data),
		.key      (key),
		.busy     (busy)
	);

	hcb_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.dst    (dst),
		.key    (key),
		.busy   (busy)
	);

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !src.ready)
		else $error("input taken during key setup");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dst.valid && dst.key_error |-> dst.first_out == 8'd0 && dst.second_out == 8'd0)
		else $error("key error item with nonzero bytes");

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("config write did not start key setup");

endmodule

`default_nettype wire
